// File: rtl/core/tafd_pkg.sv
// Shared types and constants of the triangle adjacency finder.
`default_nettype none

package tafd_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Fixed port field widths.
  localparam int VID_W = 20;
  localparam int QIDX_W = 10;
  localparam int ADJ_W = 11;
  localparam int FAR_W = 21;

  // Compare result of one stored triangle against the queried one.
  typedef struct packed {
    logic [2:0] hit;       // reversed edge k of the queried triangle is present
    logic       far_none;  // every vertex of the candidate is shared
  } match_t;

endpackage

`default_nettype wire

// File: rtl/core/tafd_store.sv
// Triangle table memory: one write port, one registered read port.
`default_nettype none

module tafd_store #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 60,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tafd_match.sv
// Reversed-edge match and far-vertex pick for one candidate triangle.
`default_nettype none

module tafd_match #(
  parameter int VB = 20
) (
  input  wire logic [3*VB-1:0] self_tri,
  input  wire logic [3*VB-1:0] cand_tri,
  output tafd_pkg::match_t     result,
  output logic [VB-1:0]        far
);

  logic [VB-1:0] s [0:2];
  logic [VB-1:0] c [0:2];
  logic [2:0]    shared;
  logic [2:0]    hit;
  logic          all_shared;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = self_tri[i*VB +: VB];
      c[i] = cand_tri[i*VB +: VB];
    end
  end

  // Edge k of the queried triangle runs s[k] -> s[k+1]; the neighbour must
  // hold it the other way round as one of its own directed edges.
  always_comb begin
    hit = 3'b000;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (c[m] == s[(k + 1) % 3] && c[(m + 1) % 3] == s[k]) begin
          hit[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shared[i] = (c[i] == s[0]) || (c[i] == s[1]) || (c[i] == s[2]);
    end
  end

  // The first candidate vertex, in stored order, that is not shared.
  always_comb begin
    all_shared = 1'b0;
    if (!shared[0]) begin
      far = c[0];
    end else if (!shared[1]) begin
      far = c[1];
    end else if (!shared[2]) begin
      far = c[2];
    end else begin
      far = c[0];
      all_shared = 1'b1;
    end
  end

  assign result = {hit, all_shared};

endmodule

`default_nettype wire

// File: rtl/core/triangle_adjacency_finder.sv
// Top level of the triangle adjacency finder: request control and table scan.
`default_nettype none

// A request is taken when start is high and busy is low. The op field picks
// one of three requests. Clear empties the table, append stores one triangle
// at the next free slot, and query looks up the triangle at query_index and
// reports up to three neighbours that share one of its edges in reverse.
// Every request gives exactly one result, shown on the result ports for one
// cycle while done is high; the receiver must take it in that cycle.
// Clear, append and a query with an index that is not stored answer in the
// cycle after the request and leave busy low, so a new request may follow
// at once. A valid query raises busy while the table is scanned. The queried
// triangle is read first, then the table memory is read at one entry per
// cycle, and finally the found neighbours are packed into the result ports.
// The single read port of the table sets this rate. Only one
// request is in work at a time, so a write and a read of the same entry
// never overlap.
// Reset empties the table; the table memory itself is never cleared, since
// entries at or above the stored count are never read.

module triangle_adjacency_finder #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int VERTEX_BITS   = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          op,
  input  wire logic [tafd_pkg::VID_W-1:0]          vertex_a,
  input  wire logic [tafd_pkg::VID_W-1:0]          vertex_b,
  input  wire logic [tafd_pkg::VID_W-1:0]          vertex_c,
  input  wire logic [tafd_pkg::QIDX_W-1:0]         query_index,
  output logic                                     done,
  output logic [1:0]                               status,
  output logic [tafd_pkg::QIDX_W-1:0]              tri_index,
  output logic [1:0]                               neighbour_count,
  output logic signed [tafd_pkg::ADJ_W-1:0]        adj_first,
  output logic signed [tafd_pkg::ADJ_W-1:0]        adj_second,
  output logic signed [tafd_pkg::ADJ_W-1:0]        adj_third,
  output logic signed [tafd_pkg::FAR_W-1:0]        far_first,
  output logic signed [tafd_pkg::FAR_W-1:0]        far_second,
  output logic signed [tafd_pkg::FAR_W-1:0]        far_third
);

  localparam int VB     = VERTEX_BITS;
  localparam int ADDR_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
  localparam int QW     = tafd_pkg::QIDX_W;
  localparam int AW     = tafd_pkg::ADJ_W;
  localparam int FW     = tafd_pkg::FAR_W;
  localparam int VW     = tafd_pkg::VID_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIANGLES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SELF = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  iss_idx;
  logic              dvld;
  logic [ADDR_W-1:0] didx;
  logic [3*VB-1:0]   self_tri;
  logic [QW-1:0]     q_reg;
  logic [2:0]        fnd;
  logic [ADDR_W-1:0] fidx [0:2];
  logic [FW-1:0]     ffar [0:2];

  logic              accept;
  logic              bad_index;
  logic              full;
  logic              issue;
  logic [CNT_W+QW-1:0] q_ext;
  logic [CNT_W+QW-1:0] cnt_ext;
  logic [VB+VW-1:0]  va_w, vb_w, vc_w;
  logic [VB+FW-1:0]  far_w;
  logic [FW-1:0]     far_conv;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [3*VB-1:0]   mem_wdata;
  logic [3*VB-1:0]   mem_rdata;

  tafd_pkg::match_t  mres;
  logic [VB-1:0]     mfar;

  logic [AW-1:0]     slot_adj [0:2];
  logic [FW-1:0]     slot_far [0:2];
  logic [1:0]        pos;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_MAX);

  assign q_ext     = {{CNT_W{1'b0}}, query_index};
  assign cnt_ext   = {{QW{1'b0}}, count};
  assign bad_index = (q_ext >= cnt_ext);

  // Vertex ids are kept to their low VERTEX_BITS bits.
  assign va_w      = {{VB{1'b0}}, vertex_a};
  assign vb_w      = {{VB{1'b0}}, vertex_b};
  assign vc_w      = {{VB{1'b0}}, vertex_c};
  assign mem_wdata = {vc_w[VB-1:0], vb_w[VB-1:0], va_w[VB-1:0]};

  assign mem_we = accept && (op == tafd_pkg::OP_APPEND) && !full;
  assign issue  = (iss_idx < count);

  // The read port serves the queried triangle first and then the scan.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = q_ext[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        mem_re    = accept && (op == tafd_pkg::OP_QUERY) && !bad_index;
        mem_raddr = q_ext[ADDR_W-1:0];
      end
      S_SELF: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_SCAN: begin
        mem_re    = issue;
        mem_raddr = iss_idx[ADDR_W-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  tafd_store #(
    .DEPTH (MAX_TRIANGLES),
    .WIDTH (3 * VB),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tafd_match #(
    .VB(VB)
  ) u_match (
    .self_tri(self_tri),
    .cand_tri(mem_rdata),
    .result  (mres),
    .far     (mfar)
  );

  // A missing far vertex reads as -1, which is all ones in the port width.
  assign far_w    = {{FW{1'b0}}, mfar};
  assign far_conv = mres.far_none ? '1 : far_w[FW-1:0];

  // Found neighbours are packed into the slots in edge order.
  always_comb begin
    logic [ADDR_W+AW-1:0] idx_w;
    for (int i = 0; i < 3; i++) begin
      slot_adj[i] = '1;
      slot_far[i] = '1;
    end
    pos = 2'd0;
    for (int k = 0; k < 3; k++) begin
      idx_w = {{AW{1'b0}}, fidx[k]};
      if (fnd[k]) begin
        slot_adj[pos] = idx_w[AW-1:0];
        slot_far[pos] = ffar[k];
        pos = pos + 2'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      dvld  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              tafd_pkg::OP_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              tafd_pkg::OP_APPEND: begin
                if (!full) begin
                  count <= count + CNT_W'(1);
                end
                done <= 1'b1;
              end
              tafd_pkg::OP_QUERY: begin
                if (bad_index) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SELF;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SELF: begin
          state <= S_SCAN;
          dvld  <= 1'b1;
        end
        S_SCAN: begin
          dvld <= issue;
          if (!dvld) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan datapath and neighbour records.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q_reg <= query_index;
      end
      S_SELF: begin
        self_tri <= mem_rdata;
        iss_idx  <= CNT_W'(1);
        didx     <= '0;
        fnd      <= 3'b000;
      end
      S_SCAN: begin
        if (issue) begin
          iss_idx <= iss_idx + CNT_W'(1);
          didx    <= iss_idx[ADDR_W-1:0];
        end
        if (dvld) begin
          // The earliest stored triangle holding a reversed edge wins.
          for (int k = 0; k < 3; k++) begin
            if (mres.hit[k] && !fnd[k]) begin
              fnd[k]  <= 1'b1;
              fidx[k] <= didx;
              ffar[k] <= far_conv;
            end
          end
        end
      end
      default: begin
        q_reg <= q_reg;
      end
    endcase
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      neighbour_count <= 2'd0;
      adj_first       <= '1;
      adj_second      <= '1;
      adj_third       <= '1;
      far_first       <= '1;
      far_second      <= '1;
      far_third       <= '1;
      tri_index       <= '0;
      status          <= tafd_pkg::ST_OK;
      case (op)
        tafd_pkg::OP_APPEND: begin
          if (full) begin
            status <= tafd_pkg::ST_FULL;
          end else begin
            tri_index <= cnt_ext[QW-1:0];
          end
        end
        tafd_pkg::OP_QUERY: begin
          tri_index <= query_index;
          if (bad_index) begin
            status <= tafd_pkg::ST_BAD_INDEX;
          end
        end
        default: begin
          status <= tafd_pkg::ST_OK;
        end
      endcase
    end else if (state == S_SCAN && !dvld) begin
      status          <= tafd_pkg::ST_OK;
      tri_index       <= q_reg;
      neighbour_count <= pos;
      adj_first       <= slot_adj[0];
      adj_second      <= slot_adj[1];
      adj_third       <= slot_adj[2];
      far_first       <= slot_far[0];
      far_second      <= slot_far[1];
      far_third       <= slot_far[2];
    end
  end

  // A result only follows a request taken at idle or the end of a scan.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state == S_SCAN)))
    else $error("result strobe without a request or a finished scan");

  // The stored count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("stored count beyond table depth");

  // A scanned entry always lies below the stored count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && dvld) |-> ({{(CNT_W - 1){1'b0}}, didx} < {1'b0, count}))
    else $error("scan read beyond stored triangles");

  // Only a good result can carry neighbours.
  a_count_status: assert property (@(posedge clk) disable iff (rst)
    (done && neighbour_count != 2'd0) |-> (status == tafd_pkg::ST_OK))
    else $error("neighbours reported with an error status");

  // A valid query always starts by reading the queried triangle.
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (accept && op == tafd_pkg::OP_QUERY && !bad_index) |=> (state == S_SELF))
    else $error("valid query did not start a scan");

endmodule

`default_nettype wire
